// File: src/ddrc_pkg.sv
// ----------------------------------------------------------------------------
// ddrc_pkg
// Shared types, register indexes and helpers of the differential drive ramp
// controller.
// ----------------------------------------------------------------------------
package ddrc_pkg;

	// Width of the bridge duty counters; every duty is saturated to its range.
	localparam int DUTY_BITS = 8;
	localparam int DUTY_MAX  = (1 << DUTY_BITS) - 1;

	// Configuration register indexes.
	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] REG_FULL_SPEED          = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_STRAIGHT_TRIM_SPEED = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CURVE_INNER_SPEED   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_RAMP_STEP           = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_RAMP_INTERVAL       = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_LIGHT_ON_LEVEL      = 3'd5;

	// Item kinds.
	localparam logic OP_BUTTON = 1'b0;
	localparam logic OP_TICK   = 1'b1;

	// Signed track speed, -255..255.
	typedef logic signed [8:0] speed_t;

	typedef struct packed {
		logic [7:0] full_speed;
		logic [7:0] straight_trim_speed;
		logic [7:0] curve_inner_speed;
		logic [7:0] ramp_step;
		logic [7:0] ramp_interval;
		logic [7:0] light_on_level;
	} ddrc_cfg_t;

	typedef struct packed {
		logic operation;
		logic key_up;
		logic key_down;
		logic key_left;
		logic key_right;
		logic key_light;
	} ddrc_item_t;

	typedef struct packed {
		logic [7:0] left_forward_duty;
		logic [7:0] left_reverse_duty;
		logic [7:0] right_forward_duty;
		logic [7:0] right_reverse_duty;
		logic [7:0] lamp_duty;
		logic       at_target;
	} ddrc_result_t;

	// Saturate a magnitude to the duty range and keep the low eight bits.
	function automatic logic [7:0] clip_duty(input logic [7:0] mag);
		logic [31:0] wide;
		wide = 32'(mag);
		if (wide > 32'(DUTY_MAX)) begin
			clip_duty = 8'(DUTY_MAX);
		end else begin
			clip_duty = mag;
		end
	endfunction

endpackage

// File: src/ddrc_cfg_regs.sv
// ----------------------------------------------------------------------------
// ddrc_cfg_regs
// Configuration register file; writes to unknown indexes are dropped.
// ----------------------------------------------------------------------------
module ddrc_cfg_regs import ddrc_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 wr_en,
	input  logic [CFG_IDX_W-1:0] wr_index,
	input  logic [7:0]           wr_data,
	output ddrc_cfg_t            cfg
);

	ddrc_cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.full_speed          <= 8'd255;
			cfg_q.straight_trim_speed <= 8'd178;
			cfg_q.curve_inner_speed   <= 8'd76;
			cfg_q.ramp_step           <= 8'd20;
			cfg_q.ramp_interval       <= 8'd5;
			cfg_q.light_on_level      <= 8'd255;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_FULL_SPEED:          cfg_q.full_speed          <= wr_data;
				REG_STRAIGHT_TRIM_SPEED: cfg_q.straight_trim_speed <= wr_data;
				REG_CURVE_INNER_SPEED:   cfg_q.curve_inner_speed   <= wr_data;
				REG_RAMP_STEP:           cfg_q.ramp_step           <= wr_data;
				REG_RAMP_INTERVAL:       cfg_q.ramp_interval       <= wr_data;
				REG_LIGHT_ON_LEVEL:      cfg_q.light_on_level      <= wr_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// File: src/ddrc_drive_core.sv
// ----------------------------------------------------------------------------
// ddrc_drive_core
// Track speed, target, ramp timer and lamp state with the single-pass update
// that one item applies, plus the result that follows from the new state.
// ----------------------------------------------------------------------------
module ddrc_drive_core import ddrc_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         en,
	input  ddrc_item_t   item,
	input  ddrc_cfg_t    cfg,
	output ddrc_result_t result
);

	logic [3:0] held_arrows_q, held_arrows_n;
	logic       held_light_q, held_light_n;
	speed_t     left_speed_q, left_speed_n;
	speed_t     left_target_q, left_target_n;
	speed_t     right_speed_q, right_speed_n;
	speed_t     right_target_q, right_target_n;
	logic [7:0] ms_q, ms_n;
	logic [7:0] lamp_q, lamp_n;

	logic [3:0] arrows;
	logic [2:0] key_count;
	logic       keys_invalid;
	logic [7:0] ms_inc;
	speed_t     f_pos, s_pos, c_pos, f_neg, s_neg, c_neg;
	speed_t     left_neg, right_neg;

	// Move a speed toward its target by at most the ramp step.
	function automatic speed_t ramp_toward(input speed_t speed, input speed_t target,
			input logic [7:0] step);
		logic signed [9:0] diff;
		logic signed [9:0] lim;
		logic signed [9:0] sum;
		diff = 10'(target) - 10'(speed);
		lim  = $signed({2'b00, step});
		if (diff > lim) begin
			diff = lim;
		end
		if (diff < -lim) begin
			diff = -lim;
		end
		sum = 10'(speed) + diff;
		ramp_toward = sum[8:0];
	endfunction

	assign arrows    = {item.key_right, item.key_left, item.key_down, item.key_up};
	assign key_count = 3'(item.key_up) + 3'(item.key_down) + 3'(item.key_left)
		+ 3'(item.key_right);
	assign keys_invalid = (key_count == 3'd0) || (key_count > 3'd2)
		|| (item.key_left && item.key_right) || (item.key_up && item.key_down);

	assign f_pos = $signed({1'b0, cfg.full_speed});
	assign s_pos = $signed({1'b0, cfg.straight_trim_speed});
	assign c_pos = $signed({1'b0, cfg.curve_inner_speed});
	assign f_neg = -f_pos;
	assign s_neg = -s_pos;
	assign c_neg = -c_pos;

	assign ms_inc = (ms_q == 8'd255) ? ms_q : ms_q + 8'd1;

	always_comb begin
		held_arrows_n  = held_arrows_q;
		held_light_n   = held_light_q;
		left_speed_n   = left_speed_q;
		left_target_n  = left_target_q;
		right_speed_n  = right_speed_q;
		right_target_n = right_target_q;
		ms_n           = ms_q;
		lamp_n         = lamp_q;
		if (item.operation == OP_BUTTON) begin
			if (arrows != held_arrows_q) begin
				held_arrows_n = arrows;
				priority if (keys_invalid) begin
					left_speed_n   = '0;
					left_target_n  = '0;
					right_speed_n  = '0;
					right_target_n = '0;
				end else if (item.key_up) begin
					priority if (item.key_left) begin
						left_target_n = c_pos; right_target_n = f_pos;
					end else if (item.key_right) begin
						left_target_n = f_pos; right_target_n = c_pos;
					end else begin
						left_target_n = f_pos; right_target_n = s_pos;
					end
				end else if (item.key_down) begin
					priority if (item.key_left) begin
						left_target_n = c_neg; right_target_n = f_neg;
					end else if (item.key_right) begin
						left_target_n = f_neg; right_target_n = c_neg;
					end else begin
						left_target_n = f_neg; right_target_n = s_neg;
					end
				end else if (item.key_left) begin
					left_target_n = f_neg; right_target_n = f_pos;
				end else begin
					left_target_n = f_pos; right_target_n = f_neg;
				end
			end
			if (item.key_light != held_light_q) begin
				held_light_n = item.key_light;
				if (item.key_light) begin
					lamp_n = (lamp_q == 8'd0) ? cfg.light_on_level : 8'd0;
				end
			end
		end else begin
			ms_n = ms_inc;
			if ((ms_inc >= cfg.ramp_interval) &&
					((left_speed_q != left_target_q) || (right_speed_q != right_target_q))) begin
				left_speed_n  = ramp_toward(left_speed_q, left_target_q, cfg.ramp_step);
				right_speed_n = ramp_toward(right_speed_q, right_target_q, cfg.ramp_step);
				ms_n          = 8'd0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_arrows_q  <= '0;
			held_light_q   <= 1'b0;
			left_speed_q   <= '0;
			left_target_q  <= '0;
			right_speed_q  <= '0;
			right_target_q <= '0;
			ms_q           <= 8'd255;
			lamp_q         <= 8'd0;
		end else if (en) begin
			held_arrows_q  <= held_arrows_n;
			held_light_q   <= held_light_n;
			left_speed_q   <= left_speed_n;
			left_target_q  <= left_target_n;
			right_speed_q  <= right_speed_n;
			right_target_q <= right_target_n;
			ms_q           <= ms_n;
			lamp_q         <= lamp_n;
		end
	end

	// The result reflects the state after this item.
	assign left_neg  = -left_speed_n;
	assign right_neg = -right_speed_n;

	always_comb begin
		result.left_forward_duty  = (left_speed_n > 9'sd0) ? clip_duty(left_speed_n[7:0]) : 8'd0;
		result.left_reverse_duty  = (left_speed_n < 9'sd0) ? clip_duty(left_neg[7:0]) : 8'd0;
		result.right_forward_duty = (right_speed_n > 9'sd0) ? clip_duty(right_speed_n[7:0]) : 8'd0;
		result.right_reverse_duty = (right_speed_n < 9'sd0) ? clip_duty(right_neg[7:0]) : 8'd0;
		result.lamp_duty          = clip_duty(lamp_n);
		result.at_target          = (left_speed_n == left_target_n)
			&& (right_speed_n == right_target_n);
	end

endmodule

// File: src/differential_drive_ramp_controller_unit.sv
// ----------------------------------------------------------------------------
// differential_drive_ramp_controller_unit
// Slew-rate limited speed control for a two-track vehicle. Each accepted item
// is either a button item (four arrow keys and a light key) or a one
// millisecond tick, and every item returns exactly one result: the forward
// and reverse H-bridge duties of both tracks, the lamp duty and a flag that
// is high when both tracks have reached their target speeds. The block takes
// one item per clock cycle while the result register does not stall; an item
// waits in the input register and its result is captured in the result
// register. The rate is set by the single combinational state update between
// those two registers. The result register and the input register stall
// together only when a result is waiting and the input register is occupied,
// so a new item is still taken while one result waits. Configuration writes
// are always ready and take effect on the next cycle; they are meant to be
// issued only while the block is idle.
// ----------------------------------------------------------------------------
module differential_drive_ramp_controller_unit import ddrc_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,

	// Item channel.
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic                 operation,
	input  logic                 key_up,
	input  logic                 key_down,
	input  logic                 key_left,
	input  logic                 key_right,
	input  logic                 key_light,

	// Result channel.
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [7:0]           left_forward_duty,
	output logic [7:0]           left_reverse_duty,
	output logic [7:0]           right_forward_duty,
	output logic [7:0]           right_reverse_duty,
	output logic [7:0]           lamp_duty,
	output logic                 at_target,

	// Configuration write channel.
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [7:0]           cfg_data
);

	ddrc_cfg_t    cfg;
	ddrc_item_t   item_s1;
	logic         valid_s1;
	ddrc_result_t result_s2;
	logic         valid_s2;
	ddrc_result_t core_result;
	logic         advance;
	logic         process;

	// The whole pipe moves when the result register is empty or being drained.
	assign advance  = !valid_s2 || out_ready;
	assign process  = valid_s1 && advance;
	assign in_ready = !valid_s1 || advance;

	// Configuration registers never stall.
	assign cfg_ready = 1'b1;

	ddrc_cfg_regs u_cfg_regs (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid && cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= '{operation: operation, key_up: key_up, key_down: key_down,
				key_left: key_left, key_right: key_right, key_light: key_light};
		end
	end

	// The core applies the item in the input register to the drive state in
	// the same cycle that its result is captured below.
	ddrc_drive_core u_drive_core (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (process),
		.item   (item_s1),
		.cfg    (cfg),
		.result (core_result)
	);

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (process) begin
			result_s2 <= core_result;
		end
	end

	assign out_valid          = valid_s2;
	assign left_forward_duty  = result_s2.left_forward_duty;
	assign left_reverse_duty  = result_s2.left_reverse_duty;
	assign right_forward_duty = result_s2.right_forward_duty;
	assign right_reverse_duty = result_s2.right_reverse_duty;
	assign lamp_duty          = result_s2.lamp_duty;
	assign at_target          = result_s2.at_target;

	// A track never drives both bridge directions at once.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (left_forward_duty == 8'd0) || (left_reverse_duty == 8'd0))
		else $error("left track drives both directions");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (right_forward_duty == 8'd0) || (right_reverse_duty == 8'd0))
		else $error("right track drives both directions");

	// An item held in the input register during a stall is not lost.
	assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !advance) |=> valid_s1 && $stable(item_s1))
		else $error("stalled item dropped from input register");

	// Every processed item yields a result on the next cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		process |=> valid_s2)
		else $error("processed item produced no result");

endmodule

// File: dv/differential_drive_ramp_controller_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// differential_drive_ramp_controller_unit_tb
// Self-checking bench for the track ramp controller. A keypad and timer
// driver pushes button items and millisecond ticks over the item channel, a
// tracking model predicts every result, and a monitor compares each result
// field by field. Register settings change between phases while the block is
// idle, and both channels see random stalls.
// ----------------------------------------------------------------------------
module differential_drive_ramp_controller_unit_tb import ddrc_pkg::*;;

	localparam int CYCLE_LIMIT = 400000;

	// Register indexes past the end of the map; writes to them are dropped.
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_LOW  = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_HIGH = 3'd7;

	// Arrow key masks, laid out as {right, left, down, up}.
	localparam logic [3:0] ARROW_UP    = 4'b0001;
	localparam logic [3:0] ARROW_DOWN  = 4'b0010;
	localparam logic [3:0] ARROW_LEFT  = 4'b0100;
	localparam logic [3:0] ARROW_RIGHT = 4'b1000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic in_valid = 1'b0;
	logic in_ready;
	logic operation = OP_BUTTON;
	logic key_up = 1'b0;
	logic key_down = 1'b0;
	logic key_left = 1'b0;
	logic key_right = 1'b0;
	logic key_light = 1'b0;

	logic out_valid;
	logic out_ready = 1'b0;
	logic [7:0] left_forward_duty;
	logic [7:0] left_reverse_duty;
	logic [7:0] right_forward_duty;
	logic [7:0] right_reverse_duty;
	logic [7:0] lamp_duty;
	logic at_target;

	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = REG_FULL_SPEED;
	logic [7:0] cfg_data = 8'd0;

	differential_drive_ramp_controller_unit dut (
		.clk                (clk),
		.arst_n             (arst_n),
		.in_valid           (in_valid),
		.in_ready           (in_ready),
		.operation          (operation),
		.key_up             (key_up),
		.key_down           (key_down),
		.key_left           (key_left),
		.key_right          (key_right),
		.key_light          (key_light),
		.out_valid          (out_valid),
		.out_ready          (out_ready),
		.left_forward_duty  (left_forward_duty),
		.left_reverse_duty  (left_reverse_duty),
		.right_forward_duty (right_forward_duty),
		.right_reverse_duty (right_reverse_duty),
		.lamp_duty          (lamp_duty),
		.at_target          (at_target),
		.cfg_valid          (cfg_valid),
		.cfg_ready          (cfg_ready),
		.cfg_index          (cfg_index),
		.cfg_data           (cfg_data)
	);

	// Items waiting to be driven, and the results the tracking model expects.
	ddrc_item_t   pad_items[$];
	ddrc_result_t expected_duties[$];

	int mismatches = 0;
	int cycle_count = 0;
	logic item_taken = 1'b0;

	// Idling controls: percent chance per slot that an idle burst starts on the
	// sender or the receiver side.
	int idle_pct = 0;
	int stall_pct = 0;
	int send_gap = 0;
	int stall_left = 0;

	// Tracking model state. The initial values are the reset values of the
	// block: all speeds and targets at rest, lamp dark, and the millisecond
	// counter saturated so that the very first tick may ramp.
	ddrc_cfg_t   cfg_now = '{8'd255, 8'd178, 8'd76, 8'd20, 8'd5, 8'd255};
	logic [3:0]  arrows_seen = 4'd0;
	logic        light_seen = 1'b0;
	speed_t      left_spd = '0;
	speed_t      left_goal = '0;
	speed_t      right_spd = '0;
	speed_t      right_goal = '0;
	logic [7:0]  ticks_since_step = 8'd255;
	logic [7:0]  lamp_now = 8'd0;

	// Saturate a magnitude to the duty range of the bridges.
	function automatic logic [7:0] duty_of(input int mag);
		if (mag > DUTY_MAX) begin
			return 8'(DUTY_MAX);
		end
		return 8'(mag);
	endfunction

	// Move a speed toward its goal by no more than one ramp step.
	function automatic speed_t slew(input speed_t spd, input speed_t goal);
		int gap;
		int lim;
		gap = int'(goal) - int'(spd);
		lim = int'(cfg_now.ramp_step);
		if (gap > lim) begin
			gap = lim;
		end
		if (gap < -lim) begin
			gap = -lim;
		end
		return speed_t'(int'(spd) + gap);
	endfunction

	// Choose new track goals for a fresh arrow set. A set that is empty, has
	// more than two keys, or holds opposing keys is an emergency stop.
	function automatic void pick_targets(input logic [3:0] a);
		speed_t f;
		speed_t s;
		speed_t c;
		f = speed_t'({1'b0, cfg_now.full_speed});
		s = speed_t'({1'b0, cfg_now.straight_trim_speed});
		c = speed_t'({1'b0, cfg_now.curve_inner_speed});
		if ($countones(a) == 0 || $countones(a) > 2 ||
				(a & (ARROW_LEFT | ARROW_RIGHT)) == (ARROW_LEFT | ARROW_RIGHT) ||
				(a & (ARROW_UP | ARROW_DOWN)) == (ARROW_UP | ARROW_DOWN)) begin
			left_spd = '0;
			left_goal = '0;
			right_spd = '0;
			right_goal = '0;
		end else if ((a & ARROW_UP) != 0) begin
			if ((a & ARROW_LEFT) != 0) begin
				left_goal = c;
				right_goal = f;
			end else if ((a & ARROW_RIGHT) != 0) begin
				left_goal = f;
				right_goal = c;
			end else begin
				left_goal = f;
				right_goal = s;
			end
		end else if ((a & ARROW_DOWN) != 0) begin
			if ((a & ARROW_LEFT) != 0) begin
				left_goal = -c;
				right_goal = -f;
			end else if ((a & ARROW_RIGHT) != 0) begin
				left_goal = -f;
				right_goal = -c;
			end else begin
				left_goal = -f;
				right_goal = -s;
			end
		end else if ((a & ARROW_LEFT) != 0) begin
			// Spin turn to the left.
			left_goal = -f;
			right_goal = f;
		end else begin
			left_goal = f;
			right_goal = -f;
		end
	endfunction

	// Advance the tracking model by one accepted item and return the result
	// that the block must produce for it.
	function automatic ddrc_result_t advance_drive(input ddrc_item_t it);
		ddrc_result_t r;
		logic [3:0] arrows;
		arrows = {it.key_right, it.key_left, it.key_down, it.key_up};
		if (it.operation == OP_BUTTON) begin
			if (arrows != arrows_seen) begin
				arrows_seen = arrows;
				pick_targets(arrows);
			end
			if (it.key_light != light_seen) begin
				light_seen = it.key_light;
				if (it.key_light) begin
					lamp_now = (lamp_now == 8'd0) ? cfg_now.light_on_level : 8'd0;
				end
			end
		end else begin
			// Key fields of a tick carry no meaning.
			if (ticks_since_step != 8'd255) begin
				ticks_since_step = ticks_since_step + 8'd1;
			end
			if (ticks_since_step >= cfg_now.ramp_interval &&
					(left_spd != left_goal || right_spd != right_goal)) begin
				left_spd = slew(left_spd, left_goal);
				right_spd = slew(right_spd, right_goal);
				ticks_since_step = 8'd0;
			end
		end
		r.left_forward_duty  = (left_spd > 0) ? duty_of(int'(left_spd)) : 8'd0;
		r.left_reverse_duty  = (left_spd < 0) ? duty_of(-int'(left_spd)) : 8'd0;
		r.right_forward_duty = (right_spd > 0) ? duty_of(int'(right_spd)) : 8'd0;
		r.right_reverse_duty = (right_spd < 0) ? duty_of(-int'(right_spd)) : 8'd0;
		r.lamp_duty          = duty_of(int'(lamp_now));
		r.at_target          = (left_spd == left_goal && right_spd == right_goal);
		return r;
	endfunction

	function automatic void compare_field(input string field, input logic [7:0] want,
			input logic [7:0] got);
		if (want !== got) begin
			$error("%s: expected %0d, got %0d", field, want, got);
			mismatches++;
		end
	endfunction

	function automatic void queue_button(input logic [3:0] a, input logic light);
		ddrc_item_t it;
		it.operation = OP_BUTTON;
		it.key_up    = (a & ARROW_UP) != 0;
		it.key_down  = (a & ARROW_DOWN) != 0;
		it.key_left  = (a & ARROW_LEFT) != 0;
		it.key_right = (a & ARROW_RIGHT) != 0;
		it.key_light = light;
		pad_items.push_back(it);
	endfunction

	// A tick carries random key fields, which the block must ignore.
	function automatic void queue_tick();
		ddrc_item_t it;
		it.operation = OP_TICK;
		{it.key_up, it.key_down, it.key_left, it.key_right, it.key_light} = 5'($urandom);
		pad_items.push_back(it);
	endfunction

	// One driving session: an arrow set, maybe a light key change with the
	// arrows held, then a run of ticks. Most sets are valid maneuvers; the
	// rest are stops and raw noise.
	task automatic queue_session(input int max_ticks, ref int budget);
		logic [3:0] a;
		logic light;
		int pick;
		int n;
		pick = $urandom_range(99);
		if (pick < 10) begin
			a = 4'($urandom);
		end else if (pick < 25) begin
			case ($urandom_range(4))
				0: a = 4'd0;
				1: a = ARROW_UP | ARROW_DOWN;
				2: a = ARROW_LEFT | ARROW_RIGHT;
				3: a = ~(4'b0001 << $urandom_range(3));
				default: a = 4'b1111;
			endcase
		end else begin
			case ($urandom_range(7))
				0: a = ARROW_UP;
				1: a = ARROW_UP | ARROW_LEFT;
				2: a = ARROW_UP | ARROW_RIGHT;
				3: a = ARROW_LEFT;
				4: a = ARROW_RIGHT;
				5: a = ARROW_DOWN;
				6: a = ARROW_DOWN | ARROW_LEFT;
				default: a = ARROW_DOWN | ARROW_RIGHT;
			endcase
		end
		light = 1'($urandom);
		queue_button(a, light);
		budget--;
		if (budget > 0 && $urandom_range(3) == 0) begin
			queue_button(a, !light);
			budget--;
		end
		n = $urandom_range(max_ticks);
		while (n > 0 && budget > 0) begin
			queue_tick();
			n--;
			budget--;
		end
	endtask

	task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
	endtask

	// Hold the sender until every item is accepted and every result is back,
	// then let the pipeline settle. Returns on a rising edge.
	task automatic wait_idle();
		do @(posedge clk); while (pad_items.size() != 0 || in_valid);
		while (expected_duties.size() != 0) begin
			@(negedge clk);
		end
		repeat (4) @(posedge clk);
	endtask

	// Reprogram all registers on an idle block, then run a batch of sessions.
	// Half way through the batch the sender stops until every result is in.
	task automatic run_phase(input ddrc_cfg_t s, input int n_items, input int max_ticks,
			input int idle);
		int budget;
		wait_idle();
		cfg_write(REG_FULL_SPEED, s.full_speed);
		cfg_write(REG_STRAIGHT_TRIM_SPEED, s.straight_trim_speed);
		cfg_write(REG_CURVE_INNER_SPEED, s.curve_inner_speed);
		cfg_write(REG_RAMP_STEP, s.ramp_step);
		cfg_write(REG_RAMP_INTERVAL, s.ramp_interval);
		cfg_write(REG_LIGHT_ON_LEVEL, s.light_on_level);
		cfg_write(REG_SPARE_LOW, 8'($urandom));
		cfg_write(REG_SPARE_HIGH, 8'($urandom));
		@(negedge clk);
		cfg_valid <= 1'b0;
		@(posedge clk);
		idle_pct = idle;
		stall_pct = idle;
		for (int half = 0; half < 2; half++) begin
			budget = (half == 0) ? n_items / 2 : n_items - n_items / 2;
			while (budget > 0) begin
				queue_session(max_ticks, budget);
			end
			if (half == 0) begin
				wait_idle();
			end
		end
	endtask

	initial begin
		forever #10 clk = ~clk;
	end

	// Sender. A new item is presented only after the previous one was
	// accepted; between items an idle burst may start.
	always @(negedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (in_valid && !item_taken) begin
			// Still waiting for the block; the item stays as it is.
		end else if (send_gap > 0) begin
			send_gap--;
			in_valid <= 1'b0;
		end else if (pad_items.size() == 0) begin
			in_valid <= 1'b0;
		end else if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
			send_gap = $urandom_range(8, 0);
			in_valid <= 1'b0;
		end else begin : present_item
			ddrc_item_t nxt;
			nxt = pad_items.pop_front();
			in_valid <= 1'b1;
			operation <= nxt.operation;
			key_up <= nxt.key_up;
			key_down <= nxt.key_down;
			key_left <= nxt.key_left;
			key_right <= nxt.key_right;
			key_light <= nxt.key_light;
		end
	end

	// Receiver. Ready drops in idle bursts.
	always @(negedge clk) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left--;
			out_ready <= 1'b0;
		end else if (stall_pct != 0 && $urandom_range(99) < stall_pct) begin
			stall_left = $urandom_range(8, 0);
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	// Monitor. Results are checked before the item accepted on the same edge
	// is predicted, so a stray result can never match a fresh expectation.
	// Register writes update the model as the block takes them.
	always @(posedge clk) begin : handshake_monitor
		ddrc_result_t want;
		ddrc_item_t took;
		if (!arst_n) begin
			item_taken = 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_duties.size() == 0) begin
					$error("result arrived with no item outstanding");
					mismatches++;
				end else begin
					want = expected_duties.pop_front();
					compare_field("left_forward_duty", want.left_forward_duty,
						left_forward_duty);
					compare_field("left_reverse_duty", want.left_reverse_duty,
						left_reverse_duty);
					compare_field("right_forward_duty", want.right_forward_duty,
						right_forward_duty);
					compare_field("right_reverse_duty", want.right_reverse_duty,
						right_reverse_duty);
					compare_field("lamp_duty", want.lamp_duty, lamp_duty);
					compare_field("at_target", 8'(want.at_target), 8'(at_target));
				end
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_FULL_SPEED:          cfg_now.full_speed = cfg_data;
					REG_STRAIGHT_TRIM_SPEED: cfg_now.straight_trim_speed = cfg_data;
					REG_CURVE_INNER_SPEED:   cfg_now.curve_inner_speed = cfg_data;
					REG_RAMP_STEP:           cfg_now.ramp_step = cfg_data;
					REG_RAMP_INTERVAL:       cfg_now.ramp_interval = cfg_data;
					REG_LIGHT_ON_LEVEL:      cfg_now.light_on_level = cfg_data;
					default: ;
				endcase
			end
			item_taken = in_valid && in_ready;
			if (item_taken) begin
				took = {operation, key_up, key_down, key_left, key_right, key_light};
				expected_duties.push_back(advance_drive(took));
			end
		end
	end

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	initial begin : stimulus
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		idle_pct = 25;
		stall_pct = 25;

		// Directed part, on the reset register values.
		queue_tick();                                // at target with a saturated counter
		queue_button(ARROW_UP, 1'b0);                // straight ahead with trim
		queue_tick();                                // ramps at once
		queue_tick();                                // interval not yet over
		queue_button(ARROW_UP | ARROW_LEFT, 1'b1);   // new goals mid-ramp, lamp on
		queue_button(ARROW_UP | ARROW_LEFT, 1'b0);   // arrows held, light key released
		repeat (5) queue_tick();                     // interval passes, ramp again
		queue_button(ARROW_UP | ARROW_RIGHT, 1'b0);
		queue_button(ARROW_LEFT, 1'b0);
		queue_button(ARROW_RIGHT, 1'b0);
		queue_button(ARROW_DOWN, 1'b0);
		queue_button(ARROW_DOWN | ARROW_LEFT, 1'b0);
		queue_button(ARROW_DOWN | ARROW_RIGHT, 1'b0);
		queue_tick();
		queue_button(ARROW_UP | ARROW_DOWN, 1'b0);   // opposing keys stop the tracks
		queue_button(ARROW_LEFT | ARROW_RIGHT, 1'b1); // lamp toggles back off
		queue_button(ARROW_UP | ARROW_DOWN | ARROW_LEFT, 1'b1);
		queue_button(4'b1111, 1'b0);
		queue_button(4'b0000, 1'b0);                 // no key at all

		// Random phases over several register settings, extremes included.
		run_phase('{8'd255, 8'd178, 8'd76, 8'd20, 8'd5, 8'd255}, 80, 15, 30);
		run_phase('{8'd255, 8'd0, 8'd255, 8'd255, 8'd1, 8'd0}, 150, 6, 0);
		run_phase('{8'd0, 8'd255, 8'd0, 8'd1, 8'd2, 8'd1}, 150, 12, 40);
		run_phase('{8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom_range(255, 1)),
			8'($urandom_range(8, 1)), 8'($urandom)}, 130, 20, 15);
		// The longest interval needs the counter to run into saturation.
		run_phase('{8'd255, 8'd128, 8'd1, 8'd255, 8'd255, 8'd128}, 300, 600, 20);
		// A zero interval ramps on every tick; a zero step ramps by nothing.
		run_phase('{8'd200, 8'd100, 8'd50, 8'd0, 8'd0, 8'd170}, 60, 5, 30);
		run_phase('{8'd170, 8'd85, 8'd34, 8'd255, 8'd0, 8'd85}, 60, 5, 30);
		// Last part: no idling on either side.
		run_phase('{8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom_range(255, 1)),
			8'($urandom_range(6, 1)), 8'($urandom)}, 150, 15, 0);

		wait_idle();
		if (mismatches == 0 && expected_duties.size() == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule
